### src/sync_length_checksum_frame_receiver_top_macros.svh
// Assertion macros of the frame receiver RTL.
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_RECEIVER_TOP_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define SLCFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("slcfr assertion failed");
// Checked at every clock edge, also during reset.
`define SLCFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("slcfr assertion failed");
`else
`define SLCFR_ASSERT(lbl, prop)
`define SLCFR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### src/slcfr_pkg.sv
// Package with types and constants of the sync/length/checksum frame receiver.
package slcfr_pkg;

  localparam logic [7:0] SYNC1_BYTE    = 8'hAA;
  localparam logic [7:0] SYNC2_BYTE    = 8'h55;
  localparam logic [7:0] ADDR_BYTES    = 8'd5;
  localparam logic [7:0] HDR_IN_LENGTH = 8'd4;
  localparam logic [8:0] LIMIT_RESET   = 9'd256;

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_GOOD   = 2'd1;
  localparam logic [1:0] ST_BADSUM = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  typedef enum logic [9:0] {
    PH_HUNT  = 10'b00_0000_0001,
    PH_SYNC2 = 10'b00_0000_0010,
    PH_SRC   = 10'b00_0000_0100,
    PH_DST   = 10'b00_0000_1000,
    PH_LEN   = 10'b00_0001_0000,
    PH_VER   = 10'b00_0010_0000,
    PH_SER   = 10'b00_0100_0000,
    PH_CMD   = 10'b00_1000_0000,
    PH_DATA  = 10'b01_0000_0000,
    PH_CHK   = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       byte_stored;
    logic [8:0] byte_index;
    logic [1:0] end_status;
    logic [8:0] frame_length;
  } res_t;

endpackage

### src/slcfr_if.sv
// Handshake channel interfaces of the frame receiver.
interface slcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       byte_stored;
  logic [8:0] byte_index;
  logic [1:0] end_status;
  logic [8:0] frame_length;

  modport source (output valid, output frame_byte, output byte_stored, output byte_index,
                  output end_status, output frame_length, input ready);
  modport sink (input valid, input frame_byte, input byte_stored, input byte_index,
                input end_status, input frame_length, output ready);
endinterface

interface slcfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] length_limit;

  modport source (output valid, output length_limit, input ready);
  modport sink (input valid, input length_limit, output ready);
endinterface

### src/slcfr_parser.sv
// Frame parser: phase register, counters and running checksum, one byte per step.
module slcfr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [8:0]        limit_i,
  output slcfr_pkg::res_t   res_o
);
  import slcfr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [8:0] count_q, count_d;
  logic [7:0] field_q, field_d;
  logic [7:0] low_q, low_d;
  logic [7:0] sum_q, sum_d;
  logic       stored;
  logic [8:0] idx;
  logic       reject;
  logic [7:0] sum_add;

  // The length is at most 16 bits, the limit at most 256: any high byte rejects.
  assign reject  = (rx_byte_i != 8'd0) || (!limit_i[8] && (low_q >= limit_i[7:0]));
  assign sum_add = sum_q + rx_byte_i;

  // A sync byte found while hunting opens a new image at index zero.
  assign idx     = (phase_q == PH_HUNT) ? 9'd0 : count_q;
  assign count_d = stored ? idx + 9'd1 : count_q;

  always_comb begin
    phase_d = phase_q;
    field_d = field_q;
    low_d   = low_q;
    sum_d   = sum_q;
    stored  = 1'b0;
    res_o.frame_byte   = rx_byte_i;
    res_o.end_status   = ST_NONE;
    res_o.frame_length = 9'd0;
    unique case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == SYNC1_BYTE) begin
          stored  = 1'b1;
          phase_d = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (rx_byte_i == SYNC2_BYTE) begin
          stored  = 1'b1;
          field_d = 8'd0;
          phase_d = PH_SRC;
        end
      end
      PH_SRC, PH_DST: begin
        stored = 1'b1;
        if (field_q == ADDR_BYTES - 8'd1) begin
          field_d = 8'd0;
          phase_d = (phase_q == PH_SRC) ? PH_DST : PH_LEN;
        end else begin
          field_d = field_q + 8'd1;
        end
      end
      PH_LEN: begin
        stored = 1'b1;
        if (field_q == 8'd0) begin
          low_d   = rx_byte_i;
          field_d = 8'd1;
        end else if (reject) begin
          res_o.end_status = ST_REJECT;
          phase_d          = PH_HUNT;
        end else begin
          field_d = low_q;
          sum_d   = 8'd0;
          phase_d = PH_VER;
        end
      end
      PH_VER, PH_SER: begin
        stored  = 1'b1;
        sum_d   = sum_add;
        phase_d = (phase_q == PH_VER) ? PH_SER : PH_CMD;
      end
      PH_CMD: begin
        stored  = 1'b1;
        sum_d   = sum_add;
        field_d = (field_q >= HDR_IN_LENGTH) ? field_q - HDR_IN_LENGTH : 8'd0;
        phase_d = (field_q > HDR_IN_LENGTH) ? PH_DATA : PH_CHK;
      end
      PH_DATA: begin
        stored  = 1'b1;
        sum_d   = sum_add;
        field_d = field_q - 8'd1;
        if (field_q == 8'd1) begin
          phase_d = PH_CHK;
        end
      end
      PH_CHK: begin
        if (sum_q == rx_byte_i) begin
          res_o.end_status   = ST_GOOD;
          res_o.frame_length = count_q;
        end else begin
          res_o.end_status = ST_BADSUM;
        end
        phase_d = PH_HUNT;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
    res_o.byte_stored = stored;
    res_o.byte_index  = stored ? idx : 9'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= 9'd0;
      field_q <= 8'd0;
      low_q   <= 8'd0;
      sum_q   <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      field_q <= field_d;
      low_q   <= low_d;
      sum_q   <= sum_d;
    end
  end

endmodule

### src/slcfr_out_buf.sv
// Two-entry output buffer: result register plus a skid register.
module slcfr_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  slcfr_pkg::res_t res_i,
  output logic            ready_o,
  slcfr_out_if.source     out_o
);
  import slcfr_pkg::*;

  res_t main_q, skid_q;
  logic main_valid_q, skid_valid_q;
  logic pop;

  assign pop     = main_valid_q && out_o.ready;
  assign ready_o = !skid_valid_q;

  assign out_o.valid        = main_valid_q;
  assign out_o.frame_byte   = main_q.frame_byte;
  assign out_o.byte_stored  = main_q.byte_stored;
  assign out_o.byte_index   = main_q.byte_index;
  assign out_o.end_status   = main_q.end_status;
  assign out_o.frame_length = main_q.frame_length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_q <= res_i;
      end else begin
        main_q <= res_i;
      end
    end
  end

endmodule

### src/sync_length_checksum_frame_receiver_top.sv
// Top level of the sync/length/checksum frame receiver.
//
// The block takes one received byte per item on in_ch_i and returns exactly one
// result item per byte on out_ch_o: the byte echoed, whether it belongs to the
// frame image and at which index, and an end status (frame good with its stored
// length, checksum mismatch, or length rejected). A frame is 0xAA, 0x55, five
// source bytes, five destination bytes, a little-endian 16-bit length, version,
// serial, command, length minus four data bytes and an additive checksum byte.
// The one register, length_limit, is written through cfg_i, which is always ready.
// Throughput is one item per cycle while an output buffer entry is free; the
// parser updates its phase, counter and 8-bit checksum once per accepted byte.
// Results sit in a two-entry output buffer, so a stalled receiver still lets one
// further item in; in_ch_i.ready drops only when both entries are full and rises
// again as soon as out_ch_o.ready takes one.
// Reset puts the parser into the hunt for 0xAA, clears the counters and the
// checksum, empties the output buffer and sets length_limit to 256.
module sync_length_checksum_frame_receiver_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  slcfr_in_if.sink     in_ch_i,
  slcfr_out_if.source  out_ch_o,
  slcfr_cfg_if.sink    cfg_i
);
  import slcfr_pkg::*;

  `include "sync_length_checksum_frame_receiver_top_macros.svh"

  logic [8:0] limit_q;
  logic [8:0] limit_d;
  logic       buf_ready;
  logic       step;
  res_t       res;

  // Configuration writes are taken at any time; the limit is clamped in the parser.
  assign cfg_i.ready = 1'b1;
  assign limit_d     = (cfg_i.valid) ? cfg_i.length_limit : limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  // An item is accepted whenever the output buffer has a free entry.
  assign in_ch_i.ready = buf_ready;
  assign step          = in_ch_i.valid && buf_ready;

  slcfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_ch_i.rx_byte),
    .limit_i   (limit_q),
    .res_o     (res)
  );

  slcfr_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .res_i   (res),
    .ready_o (buf_ready),
    .out_o   (out_ch_o)
  );

  // Backpressure on the input only comes from a held result on the output.
  `SLCFR_ASSERT_ALWAYS(a_stall_needs_result, !in_ch_i.ready |-> out_ch_o.valid)
  // The checksum byte closes a frame and is never part of the image.
  `SLCFR_ASSERT(a_chk_not_stored,
    (out_ch_o.valid && (out_ch_o.end_status == ST_GOOD ||
     out_ch_o.end_status == ST_BADSUM)) |-> !out_ch_o.byte_stored)
  // A frame length is reported only with a good frame.
  `SLCFR_ASSERT(a_len_only_good,
    (out_ch_o.valid && out_ch_o.end_status != ST_GOOD) |-> (out_ch_o.frame_length == 9'd0))
  // Bytes outside the image carry index zero.
  `SLCFR_ASSERT(a_idx_zero_unstored,
    (out_ch_o.valid && !out_ch_o.byte_stored) |-> (out_ch_o.byte_index == 9'd0))

endmodule

### tb/sv/tb_sync_length_checksum_frame_receiver_top.sv
// Self-checking testbench for the sync/length/checksum frame receiver top level.
module tb_sync_length_checksum_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slcfr_pkg::*;

  // Length limits above this value behave as this value, which bounds the image size.
  localparam logic [8:0]  LIMIT_CAP = 9'd256;
  // The length field is two bytes, low byte first.
  localparam logic [15:0] LEN_BYTES = 16'd2;
  // Percentage of cycles in which the sender or the receiver idles.
  localparam int unsigned IDLE_PCT  = 36;
  // Cycles the receiver holds off in the back-pressure phase.
  localparam int unsigned HOLD_CYCLES = 160;

  // Tracks the frame parser of the block and holds the byte reports still to come.
  class frame_image_checker;
    logic [8:0]  length_limit;
    phase_e      phase;
    logic [8:0]  stored_count;
    logic [15:0] field_count;
    logic [7:0]  length_low;
    logic [7:0]  running_sum;
    res_t        awaited_reports[$];
    int unsigned mismatch_count;

    function new();
      length_limit   = LIMIT_RESET;
      phase          = PH_HUNT;
      stored_count   = '0;
      field_count    = '0;
      length_low     = '0;
      running_sum    = '0;
      mismatch_count = 0;
    endfunction

    function void set_length_limit(logic [8:0] value);
      length_limit = value;
    endfunction

    // Advances the parser by one received byte and returns the report it causes.
    function res_t parse_rx_byte(logic [7:0] rx);
      res_t       rep;
      logic [8:0] lim;
      logic       stored;
      rep            = '0;
      rep.frame_byte = rx;
      stored         = 1'b0;
      lim            = (length_limit > LIMIT_CAP) ? LIMIT_CAP : length_limit;
      case (phase)
        PH_HUNT: begin
          if (rx == SYNC1_BYTE) begin
            stored_count = '0;
            stored       = 1'b1;
            phase        = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          // Anything but the second sync byte is dropped, a repeated 0xAA too.
          if (rx == SYNC2_BYTE) begin
            stored      = 1'b1;
            field_count = '0;
            phase       = PH_SRC;
          end
        end
        PH_SRC, PH_DST: begin
          stored      = 1'b1;
          field_count = field_count + 16'd1;
          if (field_count >= 16'(ADDR_BYTES)) begin
            field_count = '0;
            phase       = (phase == PH_SRC) ? PH_DST : PH_LEN;
          end
        end
        PH_LEN: begin
          stored      = 1'b1;
          field_count = field_count + 16'd1;
          if (field_count < LEN_BYTES) begin
            length_low = rx;
          end else begin
            field_count = {rx, length_low};
            if (field_count >= 16'(lim)) begin
              rep.end_status = ST_REJECT;
              phase          = PH_HUNT;
            end else begin
              running_sum = '0;
              phase       = PH_VER;
            end
          end
        end
        PH_VER, PH_SER: begin
          stored      = 1'b1;
          running_sum = running_sum + rx;
          phase       = (phase == PH_VER) ? PH_SER : PH_CMD;
        end
        PH_CMD: begin
          stored      = 1'b1;
          running_sum = running_sum + rx;
          field_count = (field_count >= 16'(HDR_IN_LENGTH)) ?
                        field_count - 16'(HDR_IN_LENGTH) : '0;
          phase       = (field_count != '0) ? PH_DATA : PH_CHK;
        end
        PH_DATA: begin
          stored      = 1'b1;
          running_sum = running_sum + rx;
          field_count = field_count - 16'd1;
          if (field_count == '0) phase = PH_CHK;
        end
        PH_CHK: begin
          if (running_sum == rx) begin
            rep.end_status   = ST_GOOD;
            rep.frame_length = stored_count;
          end else begin
            rep.end_status = ST_BADSUM;
          end
          phase = PH_HUNT;
        end
        default: phase = PH_HUNT;
      endcase
      if (stored) begin
        rep.byte_stored = 1'b1;
        rep.byte_index  = stored_count;
        stored_count    = stored_count + 9'd1;
      end
      return rep;
    endfunction

    function void note_rx_byte(logic [7:0] rx);
      awaited_reports.push_back(parse_rx_byte(rx));
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_byte_report(res_t got);
      res_t want;
      if (awaited_reports.size() == 0) begin
        report_mismatch($sformatf("result for byte %02h with none awaited", got.frame_byte));
        return;
      end
      want = awaited_reports.pop_front();
      if (got.frame_byte !== want.frame_byte)
        report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                  got.frame_byte, want.frame_byte));
      if (got.byte_stored !== want.byte_stored)
        report_mismatch($sformatf("byte_stored %b for byte %02h, expected %b",
                                  got.byte_stored, want.frame_byte, want.byte_stored));
      if (got.byte_index !== want.byte_index)
        report_mismatch($sformatf("byte_index %0d for byte %02h, expected %0d",
                                  got.byte_index, want.frame_byte, want.byte_index));
      if (got.end_status !== want.end_status)
        report_mismatch($sformatf("end_status %0d for byte %02h, expected %0d",
                                  got.end_status, want.frame_byte, want.end_status));
      if (got.frame_length !== want.frame_length)
        report_mismatch($sformatf("frame_length %0d for byte %02h, expected %0d",
                                  got.frame_length, want.frame_byte, want.frame_length));
    endtask
  endclass

  logic clk;
  logic rst_n;

  slcfr_in_if  in_ch();
  slcfr_out_if out_ch();
  slcfr_cfg_if cfg_ch();

  frame_image_checker checker_h;

  // Shared between the stimulus and the receiver process: a nonzero hold_left makes
  // the receiver stall until it counts down to zero, and calm switches off all random idling.
  int unsigned hold_left;
  bit          calm;
  int unsigned bytes_sent;

  logic [7:0] directed_bytes[$];

  sync_length_checksum_frame_receiver_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch),
    .cfg_i   (cfg_ch)
  );

  always #4 clk = ~clk;

  // Offers one byte and returns once the block has taken it. Before the offer the
  // sender may idle at random, so gaps land in every parser phase.
  task automatic send_byte(logic [7:0] value);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= value;
    do @(posedge clk); while (!in_ch.ready);
    checker_h.note_rx_byte(value);
    bytes_sent++;
  endtask

  // Drops valid and waits until every awaited report has come back, then lets the
  // output buffer settle before anything touches the register.
  task automatic wait_results_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (checker_h.awaited_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The configuration channel is always ready in this block, but the handshake is
  // still honored. Only called while the block has nothing in flight.
  task automatic write_length_limit(logic [8:0] value);
    @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.length_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    checker_h.set_length_limit(value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Sends one random sequence. Most are well-formed frames with random content; the
  // rest are line noise, a sync byte followed by junk, or frames with a bad checksum
  // or a rejected length. Lengths stay small except for a rare frame at the limit.
  task automatic send_random_frame(int unsigned lim_eff);
    int unsigned pick;
    int unsigned roll;
    int unsigned len;
    int unsigned upper;
    int unsigned data_len;
    logic [7:0]  sum;
    logic [7:0]  value;
    logic [7:0]  skew;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      return;
    end
    send_byte(SYNC1_BYTE);
    if (pick < 14) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      return;
    end
    // Now and then a stray byte sits between the two sync bytes, possibly a second 0xAA.
    if ($urandom_range(9) == 0) send_byte($urandom_range(1) ? SYNC1_BYTE : 8'h5A);
    send_byte(SYNC2_BYTE);
    repeat (2 * ADDR_BYTES) send_byte(8'($urandom_range(255)));

    roll = $urandom_range(99);
    if (lim_eff == 0 || roll < 15) begin
      case ($urandom_range(3))
        0:       len = lim_eff;
        1:       len = 16'hFFFF;
        2:       len = $urandom_range(65535, lim_eff);
        default: len = lim_eff + $urandom_range(3);
      endcase
    end else if (roll < 18) begin
      len = lim_eff - 1;
    end else if (roll < 30) begin
      len = $urandom_range(3);
    end else begin
      upper = (lim_eff - 1 < 20) ? lim_eff - 1 : 20;
      len   = $urandom_range(4, upper);
    end
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len >= lim_eff) return;

    // Version, serial, command and the data bytes all feed the checksum.
    data_len = (len >= 32'(HDR_IN_LENGTH)) ? len - 32'(HDR_IN_LENGTH) : 0;
    sum      = '0;
    repeat (3 + data_len) begin
      value = 8'($urandom_range(255));
      sum   = sum + value;
      send_byte(value);
    end
    if ($urandom_range(99) < 15) begin
      skew = 8'($urandom_range(1, 255));
      send_byte(sum + skew);
    end else begin
      send_byte(sum);
    end
  endtask

  // Sends random sequences under the current limit until the byte budget is spent.
  task automatic send_burst(int unsigned budget);
    int unsigned start;
    int unsigned lim_eff;
    start   = bytes_sent;
    lim_eff = 32'((checker_h.length_limit > LIMIT_CAP) ? LIMIT_CAP : checker_h.length_limit);
    while (bytes_sent - start < budget) send_random_frame(lim_eff);
  endtask

  // Receiver side: random stalls, a long hold-off on request, none while calm.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Every report the block hands over is checked against the oldest awaited one.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      checker_h.check_byte_report(res_t'{out_ch.frame_byte, out_ch.byte_stored,
                                         out_ch.byte_index, out_ch.end_status,
                                         out_ch.frame_length});
  end

  // Watchdog: far beyond the slowest correct run, including the longest frames.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.rx_byte       = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.length_limit = '0;
    hold_left           = 0;
    calm                = 1'b0;
    bytes_sent          = 0;
    checker_h           = new();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset limit: bytes outside a frame at both extremes,
    // a repeated sync byte and a wrong byte while waiting for 0x55, address bytes that
    // look like sync bytes, then a zero length, so no data, and a matching checksum.
    directed_bytes = '{8'h00, 8'hFF, SYNC1_BYTE, SYNC1_BYTE, 8'h12, SYNC2_BYTE,
                       8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F,
                       8'hFE, SYNC2_BYTE, SYNC1_BYTE, 8'h33, 8'hCC,
                       8'h00, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h80};
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Limit of 5: most lengths land below it, and no accepted frame carries data.
    wait_results_drained();
    write_length_limit(9'd5);
    send_burst(85);

    // A limit of zero rejects every frame at its length field.
    wait_results_drained();
    write_length_limit(9'd0);
    send_burst(85);

    // All-ones limit acts as 256. The receiver holds off for a long stretch at the
    // start, so the output buffer fills and the block has to stall its input.
    wait_results_drained();
    write_length_limit(9'h1FF);
    hold_left = HOLD_CYCLES;
    send_burst(85);

    // Reset value written explicitly, with idling switched off on both sides.
    wait_results_drained();
    write_length_limit(LIMIT_RESET);
    calm = 1'b1;
    send_burst(85);
    calm = 1'b0;

    // A random limit below the cap; the sender pauses midway until all reports are in.
    wait_results_drained();
    write_length_limit(9'($urandom_range(6, 255)));
    send_burst(45);
    wait_results_drained();
    send_burst(45);

    // A random limit above the cap.
    wait_results_drained();
    write_length_limit(9'($urandom_range(257, 510)));
    send_burst(85);

    // A small limit that still lets short frames with data through.
    wait_results_drained();
    write_length_limit(9'd13);
    send_burst(85);

    wait_results_drained();
    if (checker_h.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/slcfr_pkg.sv
src/slcfr_if.sv
src/slcfr_parser.sv
src/slcfr_out_buf.sv
src/sync_length_checksum_frame_receiver_top.sv
tb/sv/tb_sync_length_checksum_frame_receiver_top.sv
